### design/modexp_pkg.sv
package modexp_pkg;
  localparam int WORD_BITS = 32;
  localparam int BASE_BITS = 64;
  localparam int CNT_BITS = $clog2(BASE_BITS);
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_PUB_EXP = 2'd1;
  localparam logic [1:0] REG_PRIV_EXP = 2'd2;
  localparam logic [WORD_BITS-1:0] MODULUS_RESET = WORD_BITS'(62615533);
  localparam logic [WORD_BITS-1:0] PUB_EXP_RESET = WORD_BITS'(3);
  localparam logic [WORD_BITS-1:0] PRIV_EXP_RESET = WORD_BITS'(1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_REDUCE, ST_SQUARE, ST_MULT, ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture base, exponent, modulus; set result to one
    logic red_step;  // one bit of base reduction
    logic mul_start; // clear accumulator, load multiplier from result
    logic mul_step;  // one shift-add step
    logic mul_sq;    // operand is result itself (square) else base
    logic mul_wb;    // write accumulator back to result
    logic exp_shift; // advance exponent bit
    logic out_load;  // move result to output register
  } dp_cmd_t;

  typedef struct packed {
    logic exp_bit;
    logic mod_small; // modulus below two
  } dp_stat_t;

  // (a + b) mod m with a, b < m
  function automatic logic [WORD_BITS-1:0] add_mod(
    input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b,
    input logic [WORD_BITS-1:0] m);
    logic [WORD_BITS:0] s;
    logic [WORD_BITS:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, m};
    return d[WORD_BITS] ? s[WORD_BITS-1:0] : d[WORD_BITS-1:0];
  endfunction
endpackage

### design/modular_exponentiation_core.sv
// Computes base_value ^ exponent mod modulus by left-to-right square-and-multiply.
// One transaction at a time: the 64-bit base is first reduced bit by bit,
// then each of the 32 exponent bits costs a square plus a multiply when the
// bit is set; both use the shift-add modular multiplier, one bit per cycle;
// with a modulus below two the exponent loop is skipped.
// Result waits in an output register; write configuration only while idle.
module modular_exponentiation_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [modexp_pkg::WORD_BITS-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 op,
  input  logic [modexp_pkg::BASE_BITS-1:0]     base_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [modexp_pkg::WORD_BITS-1:0]     power_result
);
  logic [modexp_pkg::WORD_BITS-1:0] modulus, pub_exp, priv_exp;
  modexp_pkg::dp_cmd_t cmd;
  modexp_pkg::dp_stat_t stat;
  logic idle, in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= modexp_pkg::MODULUS_RESET;
      pub_exp <= modexp_pkg::PUB_EXP_RESET;
      priv_exp <= modexp_pkg::PRIV_EXP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        modexp_pkg::REG_MODULUS: modulus <= cfg_data;
        modexp_pkg::REG_PUB_EXP: pub_exp <= cfg_data;
        modexp_pkg::REG_PRIV_EXP: priv_exp <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !idle;
  assign in_fire = in_valid && idle;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  modexp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_valid && out_stall),
    .stat(stat), .cmd(cmd), .idle(idle)
  );

  modexp_dp u_dp (
    .clk(clk), .cmd(cmd), .modulus(modulus), .exponent(op ? priv_exp : pub_exp),
    .base_value(base_value), .stat(stat), .result(power_result)
  );
endmodule

### design/modexp_ctrl.sv
module modexp_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_fire,
  input  logic                         out_busy,
  input  modexp_pkg::dp_stat_t         stat,
  output modexp_pkg::dp_cmd_t          cmd,
  output logic                         idle
);
  modexp_pkg::state_t state, state_next;
  logic [modexp_pkg::CNT_BITS-1:0] cnt, cnt_next;
  logic [modexp_pkg::CNT_BITS-1:0] ebit, ebit_next;
  logic mul_busy, mul_busy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modexp_pkg::ST_IDLE;
      cnt <= '0;
      ebit <= '0;
      mul_busy <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      ebit <= ebit_next;
      mul_busy <= mul_busy_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    ebit_next = ebit;
    mul_busy_next = mul_busy;
    cmd = '0;
    idle = 1'b0;
    unique case (state)
      modexp_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          cnt_next = '1;
          state_next = modexp_pkg::ST_REDUCE;
        end
      end
      modexp_pkg::ST_REDUCE: begin
        cmd.red_step = 1'b1;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          ebit_next = modexp_pkg::CNT_BITS'(modexp_pkg::WORD_BITS - 1);
          mul_busy_next = 1'b0;
          state_next = stat.mod_small ? modexp_pkg::ST_DONE : modexp_pkg::ST_SQUARE;
        end
      end
      modexp_pkg::ST_SQUARE, modexp_pkg::ST_MULT: begin
        cmd.mul_sq = (state == modexp_pkg::ST_SQUARE);
        if (!mul_busy) begin
          cmd.mul_start = 1'b1;
          mul_busy_next = 1'b1;
          cnt_next = modexp_pkg::CNT_BITS'(modexp_pkg::WORD_BITS - 1);
        end else begin
          cmd.mul_step = 1'b1;
          cnt_next = cnt - 1'b1;
          if (cnt == '0) begin
            cmd.mul_wb = 1'b1;
            mul_busy_next = 1'b0;
            if (state == modexp_pkg::ST_SQUARE && stat.exp_bit) begin
              state_next = modexp_pkg::ST_MULT;
            end else begin
              cmd.exp_shift = 1'b1;
              ebit_next = ebit - 1'b1;
              state_next = (ebit == '0) ? modexp_pkg::ST_DONE : modexp_pkg::ST_SQUARE;
            end
          end
        end
      end
      modexp_pkg::ST_DONE: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next = modexp_pkg::ST_IDLE;
        end
      end
      default: state_next = modexp_pkg::ST_IDLE;
    endcase
  end
endmodule

### design/modexp_dp.sv
module modexp_dp (
  input  logic                                 clk,
  input  modexp_pkg::dp_cmd_t                  cmd,
  input  logic [modexp_pkg::WORD_BITS-1:0]     modulus,
  input  logic [modexp_pkg::WORD_BITS-1:0]     exponent,
  input  logic [modexp_pkg::BASE_BITS-1:0]     base_value,
  output modexp_pkg::dp_stat_t                 stat,
  output logic [modexp_pkg::WORD_BITS-1:0]     result
);
  localparam int W = modexp_pkg::WORD_BITS;
  logic [modexp_pkg::BASE_BITS-1:0] base_sh;
  logic [W-1:0] base_red, exp_reg, res, acc, mulb, mod_reg;
  logic [W:0] rem2;
  logic [W-1:0] acc2, sum;

  // restoring remainder, one base bit per cycle
  always_comb begin
    rem2 = {base_red, base_sh[modexp_pkg::BASE_BITS-1]};
    acc2 = modexp_pkg::add_mod(acc, acc, mod_reg);
    sum = mulb[W-1] ? modexp_pkg::add_mod(acc2, cmd.mul_sq ? res : base_red, mod_reg) : acc2;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_sh <= base_value;
      base_red <= '0;
      exp_reg <= exponent;
      mod_reg <= modulus;
      res <= W'(1);
    end
    if (cmd.red_step) begin
      base_sh <= {base_sh[modexp_pkg::BASE_BITS-2:0], 1'b0};
      base_red <= (rem2 >= {1'b0, mod_reg}) ? W'(rem2 - {1'b0, mod_reg}) : rem2[W-1:0];
    end
    if (cmd.mul_start) begin
      acc <= '0;
      mulb <= res;
    end
    if (cmd.mul_step) begin
      acc <= sum;
      mulb <= {mulb[W-2:0], 1'b0};
    end
    if (cmd.mul_wb) res <= sum;
    if (cmd.exp_shift) exp_reg <= {exp_reg[W-2:0], 1'b0};
    if (cmd.out_load) result <= (mod_reg < W'(2)) ? '0 : res;
  end

  assign stat.exp_bit = exp_reg[W-1];
  assign stat.mod_small = (mod_reg < W'(2));
endmodule

### design/modexp_checker.sv
module modexp_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [modexp_pkg::WORD_BITS-1:0]     power_result
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(power_result))
    else $error("result dropped while stalled");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a second transaction while busy");
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid || ($past(out_valid) && $past(out_stall)))
    else $error("result appeared too early");
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");
endmodule

bind modular_exponentiation_core modexp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .power_result(power_result)
);

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        op;
    logic [63:0] base;
  } job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = modexp_pkg::REG_MODULUS;
  logic [modexp_pkg::WORD_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = 1'b0;
  logic [modexp_pkg::BASE_BITS-1:0] base_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [modexp_pkg::WORD_BITS-1:0] power_result;

  modular_exponentiation_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .base_value(base_value),
    .out_valid(out_valid), .out_stall(out_stall), .power_result(power_result)
  );

  initial forever #6 clk = ~clk;

  // shadow registers
  logic [31:0] n_reg, e_pub, e_priv;

  job_t pending_jobs[$];
  logic [31:0] expected_powers[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 0;        // no random idling
  bit hold_out = 0;    // long receiver hold-off request
  bit sender_pause = 0;

  function automatic logic [31:0] addm(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[31:0];
  endfunction

  function automatic logic [31:0] mulm(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    logic [31:0] acc;
    acc = '0;
    for (int i = 31; i >= 0; i--) begin
      acc = addm(acc, acc, m);
      if (b[i]) acc = addm(acc, a, m);
    end
    return acc;
  endfunction

  function automatic logic [31:0] predict_power(logic sel, logic [63:0] b);
    logic [31:0] ex, r, bs;
    ex = sel ? e_priv : e_pub;
    r = '0;
    if (n_reg >= 32'd2) begin
      bs = 32'(b % {32'd0, n_reg});
      r = 32'd1;
      for (int i = 31; i >= 0; i--) begin
        r = mulm(r, r, n_reg);
        if (ex[i]) r = mulm(r, bs, n_reg);
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_powers.push_back(predict_power(op, base_value));
      end
      if (!in_valid || !in_stall) begin
        if (pending_jobs.size() > 0 && !sender_pause &&
            (calm || $urandom_range(99) >= 25)) begin
          job_t j;
          j = pending_jobs.pop_front();
          in_valid <= 1'b1;
          op <= j.op;
          base_value <= j.base;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  int hold_count = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_powers.size() == 0) begin
          $error("unexpected transaction power_result=%h", power_result);
          errors++;
        end else begin
          logic [31:0] want;
          want = expected_powers.pop_front();
          if (want !== power_result) begin
            $error("power_result expected %h actual %h", want, power_result);
            errors++;
          end
        end
      end
      if (hold_out && hold_count == 0) hold_count = 8000;
      if (hold_count > 0) begin
        hold_count--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 25);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 60000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      modexp_pkg::REG_MODULUS: n_reg = val;
      modexp_pkg::REG_PUB_EXP: e_pub = val;
      default:                 e_priv = val;
    endcase
  endtask

  task automatic drain();
    while (pending_jobs.size() > 0 || in_valid || expected_powers.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic add_job(logic sel, logic [63:0] b);
    job_t j;
    j.op = sel;
    j.base = b;
    pending_jobs.push_back(j);
  endtask

  function automatic logic [63:0] rand_base();
    case ($urandom_range(3))
      0: return {32'd0, $urandom()};
      1: return {$urandom(), $urandom()};
      2: return 64'($urandom_range(3));
      default: return ~64'($urandom_range(3));
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(4))
      0: return $urandom_range(2, 20);
      1: return 32'hffffffff - $urandom_range(3);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    n_reg = modexp_pkg::MODULUS_RESET;
    e_pub = modexp_pkg::PUB_EXP_RESET;
    e_priv = modexp_pkg::PRIV_EXP_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset keys, extreme bases
    add_job(1'b0, 64'd0);
    add_job(1'b1, 64'd1);
    add_job(1'b0, 64'hffffffffffffffff);
    add_job(1'b1, 64'd62615532);
    add_job(1'b0, 64'd62615533);
    drain();
    write_reg(modexp_pkg::REG_PUB_EXP, 32'd0);     // zero exponent
    write_reg(modexp_pkg::REG_PRIV_EXP, 32'hffffffff);
    add_job(1'b0, 64'd12345);
    add_job(1'b1, 64'hffffffffffffffff);
    add_job(1'b1, 64'h8000000000000000);
    drain();
    write_reg(modexp_pkg::REG_MODULUS, 32'hffffffff);
    add_job(1'b0, 64'hfffffffffffffffe);
    add_job(1'b1, 64'hfffffffffffffffe);
    add_job(1'b1, 64'd2);
    drain();
    write_reg(modexp_pkg::REG_MODULUS, 32'd2);
    add_job(1'b1, 64'd3);
    add_job(1'b0, 64'd4);
    drain();
    write_reg(modexp_pkg::REG_MODULUS, 32'd1);     // modulus of one
    add_job(1'b1, 64'd7);
    drain();
    write_reg(modexp_pkg::REG_MODULUS, 32'd0);     // modulus of zero
    add_job(1'b0, 64'd9);
    add_job(1'b1, 64'hffffffffffffffff);
    drain();

    // random phases with fresh keys
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(modexp_pkg::REG_MODULUS, (ph == 0) ? 32'd62615533 : rand_word());
      write_reg(modexp_pkg::REG_PUB_EXP, (ph == 1) ? 32'd65537 : rand_word());
      write_reg(modexp_pkg::REG_PRIV_EXP, rand_word());
      calm = (ph == 4);
      if (ph == 2) hold_out = 1;
      for (int k = 0; k < 30; k++) add_job(1'($urandom_range(1)), rand_base());
      if (ph == 2) begin
        repeat (20) @(posedge clk);
        hold_out = 0;
      end
      if (ph == 6) begin
        while (pending_jobs.size() > 15) @(posedge clk);
        sender_pause = 1;
        while (in_valid || expected_powers.size() > 0) @(posedge clk);
        sender_pause = 0;
      end
      drain();
    end
    calm = 0;
    repeat (3000) @(posedge clk);

    if (errors == 0 && expected_powers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
